// ===== sv/can_mbx_pkg.sv =====
// ---------------------------------------------------------------------------
// can_mbx_pkg
// Shared constants, codes and types for the CAN receive mailbox table.
// ---------------------------------------------------------------------------
package can_mbx_pkg;

  localparam int MBX_ENTRIES = 16;
  localparam int MBX_IDX_W   = $clog2(MBX_ENTRIES);
  localparam int ID_W        = 11;
  localparam int LEN_W       = 4;
  localparam int DATA_W      = 64;
  localparam int FUNC_W      = 3;
  localparam int STAT_W      = 2;
  localparam int SLOT_W      = 4;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_SET_WAIT  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ALLOC     = 3'd1;
  localparam logic [FUNC_W-1:0] FN_RELEASE   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_STORE     = 3'd3;
  localparam logic [FUNC_W-1:0] FN_FETCH_REQ = 3'd4;
  localparam logic [FUNC_W-1:0] FN_FETCH_ID  = 3'd5;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd2;

  typedef struct packed {
    logic                 load_in;   // latch operation fields
    logic                 direct;    // finish without a scan
    logic [MBX_IDX_W-1:0] raddr;     // slot read this cycle
    logic [MBX_IDX_W-1:0] pidx;      // slot whose read data is valid now
    logic                 hit_act;   // pidx matched: commit and load result
    logic                 miss_act;  // scan ended without a match
  } mbx_cmd_t;

  typedef struct packed {
    logic hit;
  } mbx_stat_t;

  // zero payload bytes at and beyond the length code
  function automatic logic [DATA_W-1:0] keep_bytes(input logic [DATA_W-1:0] data,
                                                   input logic [LEN_W-1:0] len);
    logic [DATA_W-1:0] res;
    res = '0;
    for (int b = 0; b < 8; b++) begin
      if (len > LEN_W'(b)) begin
        res[b*8 +: 8] = data[b*8 +: 8];
      end
    end
    return res;
  endfunction

endpackage

// ===== sv/can_mbx_ram.sv =====
// ---------------------------------------------------------------------------
// can_mbx_ram
// Simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module can_mbx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/can_mbx_ctrl.sv =====
// ---------------------------------------------------------------------------
// can_mbx_ctrl
// Operation sequencer: decodes an accepted beat, walks the slot range one
// read per cycle and hands hit/miss decisions to the datapath.
// ---------------------------------------------------------------------------
module can_mbx_ctrl import can_mbx_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  logic [FUNC_W-1:0] func_in,
  input  logic [SLOT_W-1:0] slot_in,
  input  mbx_stat_t         stat,
  output mbx_cmd_t          cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  localparam logic [MBX_IDX_W-1:0] IDX_FIRST = '0;
  localparam logic [MBX_IDX_W-1:0] IDX_ONE   = MBX_IDX_W'(1);
  localparam logic [MBX_IDX_W-1:0] IDX_LAST  = MBX_IDX_W'(MBX_ENTRIES - 1);

  logic [1:0]           state, state_next;
  logic [MBX_IDX_W-1:0] cnt, cnt_next;
  logic [MBX_IDX_W-1:0] end_idx, end_idx_next;
  logic                 issue_done, issue_done_next;
  logic                 pend, pend_next;
  logic [MBX_IDX_W-1:0] pidx, pidx_next;

  logic                 accept;
  logic                 scan_op;
  logic [MBX_IDX_W-1:0] start_sel, end_sel;

  // no beat is taken while reset is held
  assign s_tready = (state == S_IDLE) && !rst;
  assign m_tvalid = (state == S_OUT);
  assign accept   = s_tvalid && s_tready;

  // scan range per operation
  always_comb begin
    scan_op   = 1'b1;
    start_sel = IDX_FIRST;
    end_sel   = IDX_LAST;
    case (func_in)
      FN_ALLOC, FN_RELEASE: begin
        start_sel = IDX_ONE;
      end
      FN_STORE: begin
        scan_op   = (int'(slot_in) < MBX_ENTRIES);
        start_sel = MBX_IDX_W'(slot_in);
        end_sel   = MBX_IDX_W'(slot_in);
      end
      FN_FETCH_REQ: begin
        end_sel = IDX_FIRST;
      end
      FN_FETCH_ID: begin
        end_sel = IDX_LAST;
      end
      default: begin
        scan_op = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    end_idx_next    = end_idx;
    issue_done_next = issue_done;
    pend_next       = pend;
    pidx_next       = pidx;
    cmd             = '0;
    cmd.raddr       = cnt;
    cmd.pidx        = pidx;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load_in = 1'b1;
          if (scan_op) begin
            cnt_next        = start_sel;
            end_idx_next    = end_sel;
            issue_done_next = 1'b0;
            pend_next       = 1'b0;
            state_next      = S_SCAN;
          end else begin
            cmd.direct = 1'b1;
            state_next = S_OUT;
          end
        end
      end
      S_SCAN: begin
        // read issued at cnt; its data is compared in the next cycle at pidx
        pend_next = !issue_done;
        if (!issue_done) begin
          pidx_next = cnt;
          if (cnt == end_idx) begin
            issue_done_next = 1'b1;
          end else begin
            cnt_next = cnt + IDX_ONE;
          end
        end
        if (pend) begin
          if (stat.hit) begin
            cmd.hit_act = 1'b1;
            state_next  = S_OUT;
          end else if (pidx == end_idx) begin
            cmd.miss_act = 1'b1;
            state_next   = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      end_idx    <= '0;
      issue_done <= 1'b0;
      pend       <= 1'b0;
      pidx       <= '0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      end_idx    <= end_idx_next;
      issue_done <= issue_done_next;
      pend       <= pend_next;
      pidx       <= pidx_next;
    end
  end

  a_hit_miss_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.hit_act && cmd.miss_act))
    else $error("hit and miss in the same cycle");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted beat did not start an operation");

  a_pidx_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN && pend |-> pidx <= end_idx)
    else $error("compared slot beyond scan end");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input ready while result pending");

endmodule

// ===== sv/can_mbx_dp.sv =====
// ---------------------------------------------------------------------------
// can_mbx_dp
// Mailbox storage and match logic: ident and payload RAMs, per-slot valid
// and new flags, slot compare and the result register.
// ---------------------------------------------------------------------------
module can_mbx_dp import can_mbx_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [FUNC_W-1:0] func_in,
  input  logic [ID_W-1:0]   ident_in,
  input  logic [LEN_W-1:0]  len_in,
  input  logic [DATA_W-1:0] data_in,
  input  mbx_cmd_t          cmd,
  output mbx_stat_t         stat,
  output logic [STAT_W-1:0] status,
  output logic [SLOT_W-1:0] slot_used,
  output logic [ID_W-1:0]   ident_out,
  output logic [LEN_W-1:0]  len_out,
  output logic [DATA_W-1:0] data_out
);

  localparam int ENT_W = LEN_W + DATA_W;

  logic [FUNC_W-1:0]      func_q;
  logic [ID_W-1:0]        id_q;
  logic [LEN_W-1:0]       len_q;
  logic [DATA_W-1:0]      data_q;

  logic [MBX_ENTRIES-1:0] vld;    // ident entry written since reset, release or fetch-request
  logic [MBX_ENTRIES-1:0] newf;

  logic                   id_we;
  logic [MBX_IDX_W-1:0]   id_waddr;
  logic [ID_W-1:0]        id_wdata;
  logic [ID_W-1:0]        id_rdata;
  logic                   ent_we;
  logic [ENT_W-1:0]       ent_wdata;
  logic [ENT_W-1:0]       ent_rdata;

  logic [ID_W-1:0]        rid;
  logic                   need_new, check_id, is_fetch;
  logic [ID_W-1:0]        cmp_id;

  can_mbx_ram #(.WIDTH(ID_W), .DEPTH(MBX_ENTRIES)) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (id_waddr),
    .wdata (id_wdata),
    .raddr (cmd.raddr),
    .rdata (id_rdata)
  );

  can_mbx_ram #(.WIDTH(ENT_W), .DEPTH(MBX_ENTRIES)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (cmd.pidx),
    .wdata (ent_wdata),
    .raddr (cmd.raddr),
    .rdata (ent_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_q <= func_in;
      id_q   <= ident_in;
      len_q  <= len_in;
      data_q <= data_in;
    end
  end

  // match on the slot whose read data arrived this cycle
  assign rid      = vld[cmd.pidx] ? id_rdata : '0;
  assign need_new = (func_q == FN_FETCH_REQ) || (func_q == FN_FETCH_ID);
  assign is_fetch = need_new;
  assign check_id = (func_q != FN_FETCH_REQ);
  assign cmp_id   = (func_q == FN_ALLOC) ? '0 : id_q;
  assign stat.hit = (!need_new || newf[cmd.pidx]) && (!check_id || rid == cmp_id);

  always_comb begin
    id_we    = 1'b0;
    id_waddr = cmd.pidx;
    id_wdata = id_q;
    if (cmd.direct && func_in == FN_SET_WAIT) begin
      id_we    = 1'b1;
      id_waddr = '0;
      id_wdata = ident_in;
    end else if (cmd.hit_act && func_q == FN_ALLOC) begin
      id_we = 1'b1;
    end
  end

  assign ent_we    = cmd.hit_act && func_q == FN_STORE;
  assign ent_wdata = {len_q, keep_bytes(data_q, len_q)};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      newf <= '0;
    end else begin
      if (cmd.direct && func_in == FN_SET_WAIT) begin
        vld[0] <= 1'b1;
      end
      if (cmd.hit_act) begin
        case (func_q)
          FN_ALLOC: begin
            vld[cmd.pidx] <= 1'b1;
          end
          FN_RELEASE, FN_FETCH_REQ: begin
            vld[cmd.pidx]  <= 1'b0;
            newf[cmd.pidx] <= 1'b0;
          end
          FN_STORE: begin
            newf[cmd.pidx] <= 1'b1;
          end
          FN_FETCH_ID: begin
            newf[cmd.pidx] <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.direct) begin
      status    <= (func_in == FN_SET_WAIT) ? ST_OK : ST_NONE;
      slot_used <= '0;
      ident_out <= '0;
      len_out   <= '0;
      data_out  <= '0;
    end else if (cmd.miss_act) begin
      status    <= (func_q == FN_ALLOC) ? ST_FULL : ST_NONE;
      slot_used <= '0;
      ident_out <= '0;
      len_out   <= '0;
      data_out  <= '0;
    end else if (cmd.hit_act) begin
      status    <= ST_OK;
      slot_used <= SLOT_W'(cmd.pidx);
      ident_out <= is_fetch ? rid : '0;
      len_out   <= is_fetch ? ent_rdata[DATA_W +: LEN_W] : '0;
      data_out  <= is_fetch ? ent_rdata[DATA_W-1:0] : '0;
    end
  end

  a_store_sets_new: assert property (@(posedge clk) disable iff (rst)
    cmd.hit_act && func_q == FN_STORE |=> newf[$past(cmd.pidx)])
    else $error("stored slot not flagged new");

endmodule

// ===== sv/can_receive_mailbox_table_core.sv =====
// ---------------------------------------------------------------------------
// can_receive_mailbox_table_core
// Receive mailbox table for standard CAN identifiers, stream interface.
// ---------------------------------------------------------------------------
// One operation is in flight at a time: s_tready is high only while the
// block is idle and out of reset, and the result beat on the master side
// must be taken before the next operation is accepted. Set-wait and unknown
// codes are decided in the accepting cycle itself. All other operations
// then walk the ident RAM one slot per cycle, each read registered before
// its compare: a store reads only its own slot, a fetch-request only slot
// 0, an allocate or release slots 1 to MBX_ENTRIES - 1 and a fetch-by-ident
// every slot, stopping early at the first match; m_tvalid then stays up
// until the sink takes the result. The single RAM read port sets the pace.
// Slot idents and new flags reset to free/clear at once, with no sweep.
// ---------------------------------------------------------------------------
module can_receive_mailbox_table_core import can_mbx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // ident[10:0], slot[14:11], frame_len[18:15],
                                 // frame_data[82:19], zero pad
  input  logic [2:0]  s_tuser,   // func[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // slot_used[3:0], ident_out[14:4], len_out[18:15],
                                 // data_out[82:19], zero pad
  output logic [1:0]  m_tuser    // status[1:0]
);

  mbx_cmd_t          cmd;
  mbx_stat_t         stat;
  logic [STAT_W-1:0] status;
  logic [SLOT_W-1:0] slot_used;
  logic [ID_W-1:0]   ident_out;
  logic [LEN_W-1:0]  len_out;
  logic [DATA_W-1:0] data_out;

  can_mbx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .func_in  (s_tuser),
    .slot_in  (s_tdata[14:11]),
    .stat     (stat),
    .cmd      (cmd)
  );

  can_mbx_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .func_in   (s_tuser),
    .ident_in  (s_tdata[10:0]),
    .len_in    (s_tdata[18:15]),
    .data_in   (s_tdata[82:19]),
    .cmd       (cmd),
    .stat      (stat),
    .status    (status),
    .slot_used (slot_used),
    .ident_out (ident_out),
    .len_out   (len_out),
    .data_out  (data_out)
  );

  assign m_tdata = {5'b0, data_out, len_out, ident_out, slot_used};
  assign m_tuser = status;

endmodule
